// ----- sv/assert_macros.svh -----
// assertion macros used by the buffer pool manager top level
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define CBPM_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define CBPM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/cbpm_pkg.sv -----
// shared types and codes for the buffer pool manager
// used by cbpm_ctrl, cbpm_dp and the top level; no dependencies
package cbpm_pkg;

    // fixed widths of the stream fields
    localparam int FILE_W  = 8;
    localparam int PAGE_W  = 16;
    localparam int FRAME_W = 4;

    // request actions
    localparam logic [1:0] ACT_READ    = 2'd0;
    localparam logic [1:0] ACT_ALLOC   = 2'd1;
    localparam logic [1:0] ACT_UNPIN   = 2'd2;
    localparam logic [1:0] ACT_DISPOSE = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_ABSENT   = 2'd2;
    localparam logic [1:0] ST_UNPINNED = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch;       // capture the incoming request
        logic srch_init;   // start the lookup at frame zero
        logic srch_run;    // compare one frame, update it on a hit
        logic scan_init;   // start the clock scan after the hand
        logic scan_run;    // examine one frame under the hand
        logic push;        // move the finished result to the output register
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic hit;         // current frame holds the requested page
        logic srch_last;   // current frame is the last one of the table
        logic is_alloc;    // request may need a new frame (read or alloc)
        logic scan_done;   // scan found a frame or gave up
        logic out_free;    // output register can take a result
    } stat_t;

    // one result transaction, first field in the highest bits
    typedef struct packed {
        logic              fetch_valid;
        logic [PAGE_W-1:0] writeback_page;
        logic [FILE_W-1:0] writeback_file;
        logic              writeback_valid;
        logic [FRAME_W-1:0] frame;
        logic [1:0]        status;
    } result_t;

endpackage

// ----- sv/cbpm_ctrl.sv -----
// sequencing state machine for the buffer pool manager
// depends on cbpm_pkg for the command and status structs
module cbpm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  cbpm_pkg::stat_t stat,
    output cbpm_pkg::cmd_t  cmd
);
    import cbpm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH0 = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_SCAN0 = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_SRCH0;
                end
            end
            S_SRCH0:
            begin
                cmd.srch_init = 1'b1;
                state_next    = S_SRCH;
            end
            S_SRCH:
            begin
                cmd.srch_run = 1'b1;
                if (stat.hit)
                begin
                    state_next = S_PUSH;
                end
                else if (stat.srch_last)
                begin
                    state_next = stat.is_alloc ? S_SCAN0 : S_PUSH;
                end
            end
            S_SCAN0:
            begin
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// ----- sv/cbpm_dp.sv -----
// frame table datapath: descriptor memory, valid bits, clock hand and result registers
// depends on cbpm_pkg; driven by commands from cbpm_ctrl
module cbpm_dp #(
    parameter int NUM_FRAMES   = 16,
    parameter int FILE_ID_BITS = 8,
    parameter int PAGE_BITS    = 16,
    parameter int PIN_BITS     = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cbpm_pkg::cmd_t            cmd,
    output cbpm_pkg::stat_t           stat,
    input  logic [1:0]                in_action,
    input  logic [cbpm_pkg::FILE_W-1:0] in_file,
    input  logic [cbpm_pkg::PAGE_W-1:0] in_page,
    input  logic                      in_dirty,
    input  logic                      out_ready,
    output logic                      out_valid,
    output cbpm_pkg::result_t         out_result
);
    import cbpm_pkg::*;

    localparam int IDX_W = $clog2(NUM_FRAMES);
    localparam int CNT_W = $clog2(2 * NUM_FRAMES);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_FRAMES - 1);
    localparam logic [CNT_W-1:0] PASS_LAST = CNT_W'(2 * NUM_FRAMES - 1);

    typedef struct packed {
        logic [FILE_ID_BITS-1:0] owner;
        logic [PAGE_BITS-1:0]    page;
        logic                    dirty;
        logic                    refd;
        logic [PIN_BITS-1:0]     pins;
    } entry_t;

    // frame descriptor memory, one read and one write port
    entry_t mem [NUM_FRAMES];
    entry_t rd_reg;

    // request registers
    logic [1:0]              act_reg;
    logic [FILE_ID_BITS-1:0] file_reg;
    logic [PAGE_BITS-1:0]    page_reg;
    logic                    md_reg;

    // control registers
    logic [NUM_FRAMES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [IDX_W-1:0]      hand_reg, hand_next;
    logic [CNT_W-1:0]      pass_reg, pass_next;
    logic                  out_valid_reg, out_valid_next;

    // result registers
    result_t res_reg, res_next;
    result_t out_reg;

    // combinational helpers
    logic [IDX_W-1:0]    cur_wrap, hand_wrap, rd_addr;
    logic                cur_valid, tag_match, pinned, victim, take, second_chance;
    logic                is_alloc;
    logic [PIN_BITS-1:0] pins_inc;
    logic [FRAME_W-1:0]  cur_frame;
    logic                wr_en;
    entry_t              wr_data, new_entry;

    assign cur_wrap  = (cur_reg == LAST_IDX) ? '0 : cur_reg + IDX_W'(1);
    assign hand_wrap = (hand_reg == LAST_IDX) ? '0 : hand_reg + IDX_W'(1);
    assign cur_valid = valid_reg[cur_reg];
    assign tag_match = cur_valid && (rd_reg.owner == file_reg) && (rd_reg.page == page_reg);
    assign pinned    = (rd_reg.pins != '0);
    assign victim    = cur_valid && !pinned && !rd_reg.refd;
    assign second_chance = cur_valid && !pinned && rd_reg.refd;
    assign take      = !cur_valid || victim;
    assign is_alloc  = (act_reg == ACT_READ) || (act_reg == ACT_ALLOC);
    assign pins_inc  = (&rd_reg.pins) ? rd_reg.pins : rd_reg.pins + PIN_BITS'(1);
    assign cur_frame = FRAME_W'(32'(cur_reg));

    // fresh descriptor for a newly placed page
    always_comb
    begin
        new_entry       = rd_reg;
        new_entry.owner = file_reg;
        new_entry.page  = page_reg;
        new_entry.dirty = 1'b0;
        new_entry.refd  = 1'b1;
        new_entry.pins  = PIN_BITS'(1);
    end

    // status to the controller
    always_comb
    begin
        stat.hit       = tag_match;
        stat.srch_last = (cur_reg == LAST_IDX);
        stat.is_alloc  = is_alloc;
        stat.scan_done = take || (pass_reg == PASS_LAST);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    // read address for the next cycle
    always_comb
    begin
        if (cmd.srch_init)
        begin
            rd_addr = '0;
        end
        else if (cmd.scan_init)
        begin
            rd_addr = hand_wrap;
        end
        else if (cmd.srch_run || cmd.scan_run)
        begin
            rd_addr = cur_wrap;
        end
        else
        begin
            rd_addr = cur_reg;
        end
    end

    // lookup, scan and result logic
    always_comb
    begin
        valid_next = valid_reg;
        cur_next   = cur_reg;
        hand_next  = hand_reg;
        pass_next  = pass_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_data    = rd_reg;

        if (cmd.srch_init)
        begin
            cur_next = '0;
        end

        if (cmd.scan_init)
        begin
            cur_next  = hand_wrap;
            pass_next = '0;
        end

        // lookup: one frame a cycle, update the frame on a hit
        if (cmd.srch_run)
        begin
            cur_next = cur_wrap;
            if (tag_match)
            begin
                res_next       = '0;
                res_next.frame = cur_frame;
                case (act_reg)
                    ACT_READ, ACT_ALLOC:
                    begin
                        wr_en        = 1'b1;
                        wr_data.refd = 1'b1;
                        wr_data.pins = pins_inc;
                        res_next.status = ST_OK;
                    end
                    ACT_UNPIN:
                    begin
                        if (!pinned)
                        begin
                            res_next.status = ST_UNPINNED;
                        end
                        else
                        begin
                            wr_en         = 1'b1;
                            wr_data.pins  = rd_reg.pins - PIN_BITS'(1);
                            wr_data.dirty = rd_reg.dirty | md_reg;
                            res_next.status = ST_OK;
                        end
                    end
                    ACT_DISPOSE:
                    begin
                        valid_next[cur_reg] = 1'b0;
                        res_next.status     = ST_OK;
                    end
                    default:
                    begin
                        res_next.status = ST_OK;
                    end
                endcase
            end
            else if ((cur_reg == LAST_IDX) && !is_alloc)
            begin
                res_next        = '0;
                res_next.status = ST_ABSENT;
            end
        end

        // clock scan: one frame a cycle under the hand
        if (cmd.scan_run)
        begin
            cur_next  = cur_wrap;
            hand_next = cur_reg;
            pass_next = pass_reg + CNT_W'(1);
            if (take)
            begin
                wr_en               = 1'b1;
                wr_data             = new_entry;
                valid_next[cur_reg] = 1'b1;
                res_next            = '0;
                res_next.status     = ST_OK;
                res_next.frame      = cur_frame;
                res_next.fetch_valid = (act_reg == ACT_READ);
                if (victim && rd_reg.dirty)
                begin
                    res_next.writeback_valid = 1'b1;
                    res_next.writeback_file  = FILE_W'(32'(rd_reg.owner));
                    res_next.writeback_page  = PAGE_W'(32'(rd_reg.page));
                end
            end
            else
            begin
                if (second_chance)
                begin
                    wr_en        = 1'b1;
                    wr_data.refd = 1'b0;
                end
                if (pass_reg == PASS_LAST)
                begin
                    res_next        = '0;
                    res_next.status = ST_FULL;
                end
            end
        end
    end

    assign out_valid_next = cmd.push || (out_valid_reg && !out_ready);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            cur_reg       <= '0;
            hand_reg      <= LAST_IDX;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            cur_reg       <= cur_next;
            hand_reg      <= hand_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg  <= in_action;
            file_reg <= FILE_ID_BITS'(32'(in_file));
            page_reg <= PAGE_BITS'(32'(in_page));
            md_reg   <= in_dirty;
        end
        res_reg <= res_next;
        if (cmd.push)
        begin
            out_reg <= res_reg;
        end
    end

    // descriptor memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cur_reg] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

// ----- sv/clock_buffer_pool_manager_unit.sv -----
// top level of the buffer pool frame table with clock replacement
// depends on cbpm_pkg, cbpm_ctrl, cbpm_dp and assert_macros.svh
`include "assert_macros.svh"

// Frame table for a page buffer pool. Each request (read, alloc, unpin or
// dispose a page) gives exactly one result transaction. After the request
// is accepted, the lookup reads the descriptors from frame zero on and stops
// at the frame that holds the page or at the last frame; a miss on unpin or
// dispose then gives an absent result, and a read or alloc miss starts the
// clock scan at the frame after the hand, which visits 1 to 2 * NUM_FRAMES
// frames. Both the lookup and the clock scan step through the descriptor
// memory one frame a cycle; a finished result then waits until the output
// register can take it. One request is in work at a time; the next one is
// taken the cycle after a result moves to the output register, and that
// result waits there while the next request is served. No clearing pass is
// needed after reset.
module clock_buffer_pool_manager_unit #(
    parameter int NUM_FRAMES   = 16,
    parameter int FILE_ID_BITS = 8,
    parameter int PAGE_BITS    = 16,
    parameter int PIN_BITS     = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // file_id[7:0], page_no[23:8], mark_dirty[24], zero pad
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // status[1:0], frame[5:2], writeback_valid[6],
                                   // writeback_file[14:7], writeback_page[30:15],
                                   // fetch_valid[31]
);
    import cbpm_pkg::*;

    cmd_t    cmd;
    stat_t   stat;
    result_t m_result;

    // sequencing
    cbpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // frame table
    cbpm_dp #(
        .NUM_FRAMES   (NUM_FRAMES),
        .FILE_ID_BITS (FILE_ID_BITS),
        .PAGE_BITS    (PAGE_BITS),
        .PIN_BITS     (PIN_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_action  (s_tuser),
        .in_file    (s_tdata[7:0]),
        .in_page    (s_tdata[23:8]),
        .in_dirty   (s_tdata[24]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_result (m_result)
    );

    assign m_tdata = m_result;

    // checks
    `CBPM_ASSERT_RST(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready, "request taken while busy")
    `CBPM_ASSERT_RST(a_out_from_push, $rose(m_tvalid) |-> $past(cmd.push), "output raised without push")
    `CBPM_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
    `CBPM_ASSERT_RST(a_fetch_ok, (m_tvalid && m_result.fetch_valid) |-> (m_result.status == ST_OK), "fetch with failing status")

endmodule
